>>> hdl/apm_pkg.sv
// ----------------------------------------------------------------------------
// apm_pkg
// types, codes and constants shared by the power-management register block
// ----------------------------------------------------------------------------
package apm_pkg;

    localparam int unsigned DATA_W   = 8;
    localparam int unsigned OFFSET_W = 6;
    localparam int unsigned SLP_W    = 3;
    localparam int unsigned TIMER_W  = 24;

    // operation codes
    localparam logic [1:0] OP_READ  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_TICK  = 2'd2;
    localparam logic [1:0] OP_NOP   = 2'd3;

    // error codes
    localparam logic [1:0] ERR_NONE     = 2'd0;
    localparam logic [1:0] ERR_UNMAPPED = 2'd1;
    localparam logic [1:0] ERR_SLP_TYPE = 2'd2;

    // register select, offset bits 5..2
    localparam logic [3:0] REG_STS_EN = 4'h0;
    localparam logic [3:0] REG_CTRL   = 4'h1;
    localparam logic [3:0] REG_TIMER  = 4'h2;

    localparam int unsigned SUS_EN_BIT  = 13;
    localparam int unsigned SLP_TYP_LSB = 10;
    localparam int unsigned TMR_EN_BIT  = 16;
    localparam int unsigned TMR_STS_BIT = 0;

    localparam logic [31:0]        CTRL_RESET  = 32'h0000_0001;
    localparam logic [SLP_W-1:0]   SLP_RESET   = 3'd5;
    localparam logic [TIMER_W-1:0] TIMER_LAST  = 24'hFF_FFFF;

    typedef struct packed {
        logic [1:0]          op;
        logic [OFFSET_W-1:0] offset;
        logic [DATA_W-1:0]   wdata;
    } in_beat_t;

    typedef struct packed {
        logic [DATA_W-1:0] rdata;
        logic              irq_level;
        logic              suspend_req;
        logic [1:0]        error;
    } out_beat_t;

endpackage

>>> hdl/apm_core.sv
// ----------------------------------------------------------------------------
// apm_core
// status/enable, control and timer registers with their per-beat update
// ----------------------------------------------------------------------------
module apm_core
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      accept,
    input  apm_pkg::in_beat_t         beat,
    input  logic                      cfg_we,
    input  logic [apm_pkg::SLP_W-1:0] cfg_wdata,
    output apm_pkg::out_beat_t        result
);

    logic [31:0]                  sts_en_reg, sts_en_next;
    logic [31:0]                  ctrl_reg, ctrl_next;
    logic [apm_pkg::TIMER_W-1:0]  timer_reg, timer_next;
    logic [apm_pkg::SLP_W-1:0]    slp_type_reg;

    logic [3:0]  reg_sel;
    logic [4:0]  shift;
    logic [31:0] lane_mask;
    logic [31:0] wd_lane;
    logic [31:0] ctrl_wr;
    logic [31:0] sts_rd;
    logic [31:0] ctrl_rd;
    logic [31:0] timer_rd;

    assign reg_sel   = beat.offset[5:2];
    assign shift     = {beat.offset[1:0], 3'b000};
    assign lane_mask = 32'h0000_00FF << shift;
    assign wd_lane   = {24'h00_0000, beat.wdata} << shift;
    assign ctrl_wr   = (ctrl_reg & ~lane_mask) | wd_lane;
    assign sts_rd    = sts_en_reg >> shift;
    assign ctrl_rd   = ctrl_reg >> shift;
    // top byte of the timer window reads zero
    assign timer_rd  = {8'h00, timer_reg} >> shift;

    always_comb
    begin
        sts_en_next        = sts_en_reg;
        ctrl_next          = ctrl_reg;
        timer_next         = timer_reg;
        result.rdata       = '0;
        result.suspend_req = 1'b0;
        result.error       = apm_pkg::ERR_NONE;

        unique case (beat.op)
            apm_pkg::OP_READ:
            begin
                priority if (reg_sel == apm_pkg::REG_STS_EN)
                    result.rdata = sts_rd[7:0];
                else if (reg_sel == apm_pkg::REG_CTRL)
                    result.rdata = ctrl_rd[7:0];
                else if (reg_sel == apm_pkg::REG_TIMER)
                    result.rdata = timer_rd[7:0];
                else
                    result.error = apm_pkg::ERR_UNMAPPED;
            end
            apm_pkg::OP_WRITE:
            begin
                priority if (reg_sel == apm_pkg::REG_STS_EN)
                begin
                    // status lanes clear on one, enable lanes replace
                    if (!beat.offset[1])
                        sts_en_next = sts_en_reg & ~wd_lane;
                    else
                        sts_en_next = (sts_en_reg & ~lane_mask) | wd_lane;
                end
                else if (reg_sel == apm_pkg::REG_CTRL)
                begin
                    ctrl_next = ctrl_wr;
                    if (ctrl_wr[apm_pkg::SUS_EN_BIT])
                    begin
                        if (ctrl_wr[apm_pkg::SLP_TYP_LSB +: apm_pkg::SLP_W] == slp_type_reg)
                            result.suspend_req = 1'b1;
                        else
                            result.error = apm_pkg::ERR_SLP_TYPE;
                        ctrl_next[apm_pkg::SUS_EN_BIT] = 1'b0;
                    end
                end
                else
                    result.error = apm_pkg::ERR_UNMAPPED;
            end
            apm_pkg::OP_TICK:
            begin
                timer_next = timer_reg + 1'b1;
                if (timer_reg == apm_pkg::TIMER_LAST)
                    sts_en_next[apm_pkg::TMR_STS_BIT] = 1'b1;
            end
            default:
            begin
                // no operation
            end
        endcase

        result.irq_level = sts_en_next[apm_pkg::TMR_STS_BIT]
                         & sts_en_next[apm_pkg::TMR_EN_BIT];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sts_en_reg   <= '0;
            ctrl_reg     <= apm_pkg::CTRL_RESET;
            timer_reg    <= '0;
            slp_type_reg <= apm_pkg::SLP_RESET;
        end
        else
        begin
            if (accept)
            begin
                sts_en_reg <= sts_en_next;
                ctrl_reg   <= ctrl_next;
                timer_reg  <= timer_next;
            end
            if (cfg_we)
                slp_type_reg <= cfg_wdata;
        end
    end

endmodule

>>> hdl/apm_out_stage.sv
// ----------------------------------------------------------------------------
// apm_out_stage
// result register with valid/ready towards the receiver
// ----------------------------------------------------------------------------
module apm_out_stage
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               load,
    input  apm_pkg::out_beat_t result,
    output logic               can_load,
    output logic               out_valid,
    input  logic               out_ready,
    output apm_pkg::out_beat_t out_data
);

    logic               valid_reg;
    apm_pkg::out_beat_t data_reg;

    // free when empty or when the held beat leaves this cycle
    assign can_load  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (can_load)
            valid_reg <= load;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            data_reg <= result;
    end

endmodule

>>> hdl/acpi_pm_register_block_top.sv
// ----------------------------------------------------------------------------
// acpi_pm_register_block_top
// byte-wide power-management register window with 24-bit timer
// ----------------------------------------------------------------------------
// usage:
//   in channel (in_valid/in_ready/in_data) carries one beat per access: a byte
//   read, a byte write or a timer tick, with a 6-bit offset and write byte.
//   out channel (out_valid/out_ready/out_data) returns exactly one beat per
//   input beat: read byte, interrupt level, suspend pulse and error code.
//   cfg_we/cfg_wdata set the accepted sleep type at any edge, no handshake.
//   out_valid rises in the cycle after input acceptance; throughput is one
//   beat per cycle unless the receiver stalls, the register update and result
//   both settle in the single combinational pass ahead of the result register.
//   when the receiver stalls the result register holds its beat and in_ready
//   drops; a new beat is taken in the same cycle the held one leaves.
//   reset clears status/enable and timer, sets control to one, the sleep
//   type to five and empties the result register.
// ----------------------------------------------------------------------------
module acpi_pm_register_block_top
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  apm_pkg::in_beat_t         in_data,
    output logic                      out_valid,
    input  logic                      out_ready,
    output apm_pkg::out_beat_t        out_data,
    input  logic                      cfg_we,
    input  logic [apm_pkg::SLP_W-1:0] cfg_wdata
);

    logic               accept;
    apm_pkg::out_beat_t result;

    assign accept = in_valid && in_ready;

    apm_core u_core
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .beat      (in_data),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .result    (result)
    );

    apm_out_stage u_out
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (accept),
        .result    (result),
        .can_load  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule
